// File: hw/rtl/pbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared types, constants and helpers of the framebuffer pixel blend stage.
// ----------------------------------------------------------------------------
package pbf_pkg;

    localparam int PBF_FB_WIDTH  = 640;
    localparam int PBF_FB_HEIGHT = 528;
    localparam int PBF_WORD_W    = 24;

    // pixel formats
    localparam logic [1:0] FMT_RGB8   = 2'd0;
    localparam logic [1:0] FMT_RGBA6  = 2'd1;
    localparam logic [1:0] FMT_RGB565 = 2'd2;
    localparam logic [1:0] FMT_Z24    = 2'd3;

    // transaction kinds
    localparam logic [1:0] KIND_BLEND = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_PIX_FMT      = 3'd0;
    localparam logic [2:0] CFG_MODE_FLAGS   = 3'd1;
    localparam logic [2:0] CFG_SRC_FACTOR   = 3'd2;
    localparam logic [2:0] CFG_DST_FACTOR   = 3'd3;
    localparam logic [2:0] CFG_LOGIC_OP     = 3'd4;
    localparam logic [2:0] CFG_CONST_A_EN   = 3'd5;
    localparam logic [2:0] CFG_CONST_A_VAL  = 3'd6;

    // mode flag bits
    localparam int MODE_BLEND    = 0;
    localparam int MODE_SUBTRACT = 1;
    localparam int MODE_LOGIC    = 2;
    localparam int MODE_DITHER   = 3;
    localparam int MODE_COLOR_UP = 4;
    localparam int MODE_ALPHA_UP = 5;

    // blend factors (source and destination share the encoding slots)
    localparam logic [2:0] BF_ZERO        = 3'd0;
    localparam logic [2:0] BF_ONE         = 3'd1;
    localparam logic [2:0] BF_OTHER       = 3'd2;
    localparam logic [2:0] BF_INV_OTHER   = 3'd3;
    localparam logic [2:0] BF_SRC_ALPHA   = 3'd4;
    localparam logic [2:0] BF_INV_SRC_A   = 3'd5;
    localparam logic [2:0] BF_DST_ALPHA   = 3'd6;
    localparam logic [2:0] BF_INV_DST_A   = 3'd7;

    // logic ops
    localparam logic [3:0] LOP_CLEAR    = 4'd0;
    localparam logic [3:0] LOP_AND      = 4'd1;
    localparam logic [3:0] LOP_AND_REV  = 4'd2;
    localparam logic [3:0] LOP_COPY     = 4'd3;
    localparam logic [3:0] LOP_AND_INV  = 4'd4;
    localparam logic [3:0] LOP_NOOP     = 4'd5;
    localparam logic [3:0] LOP_XOR      = 4'd6;
    localparam logic [3:0] LOP_OR       = 4'd7;
    localparam logic [3:0] LOP_NOR      = 4'd8;
    localparam logic [3:0] LOP_EQUIV    = 4'd9;
    localparam logic [3:0] LOP_INVERT   = 4'd10;
    localparam logic [3:0] LOP_OR_REV   = 4'd11;
    localparam logic [3:0] LOP_COPY_INV = 4'd12;
    localparam logic [3:0] LOP_OR_INV   = 4'd13;
    localparam logic [3:0] LOP_NAND     = 4'd14;
    localparam logic [3:0] LOP_SET      = 4'd15;

    localparam logic [1:0] BAYER [2][2] = '{'{2'd0, 2'd2}, '{2'd3, 2'd1}};

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    typedef struct packed {
        logic [1:0] pix_fmt;
        logic [5:0] mode_flags;
        logic [2:0] src_factor;
        logic [2:0] dst_factor;
        logic [3:0] logic_op;
        logic       const_a_en;
        logic [7:0] const_a_val;
    } t_cfg;

    function automatic logic [7:0] f_expand6(input logic [5:0] v);
        f_expand6 = {v, v[5:4]};
    endfunction

    function automatic t_rgba f_decode(input logic [PBF_WORD_W-1:0] w,
                                       input logic [1:0] fmt);
        t_rgba c;
        if (fmt == FMT_RGBA6) begin
            c.a = f_expand6(w[5:0]);
            c.b = f_expand6(w[11:6]);
            c.g = f_expand6(w[17:12]);
            c.r = f_expand6(w[23:18]);
        end else begin
            c.a = 8'hff;
            c.b = w[7:0];
            c.g = w[15:8];
            c.r = w[23:16];
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/pbf_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_lane
// One channel of factor blending or floored subtract.
// ----------------------------------------------------------------------------
module pbf_lane
    import pbf_pkg::*;
(
    input  logic [7:0] i_src,
    input  logic [7:0] i_dst,
    input  logic [7:0] i_src_alpha,
    input  logic [7:0] i_dst_alpha,
    input  logic [2:0] i_src_factor,
    input  logic [2:0] i_dst_factor,
    input  logic       i_subtract,
    output logic [7:0] o_res
);

    logic [7:0]  sf, df;
    logic [8:0]  sf_adj, df_adj;
    logic [16:0] s_prod, d_prod;
    logic [17:0] sum;
    logic [9:0]  shifted;

    function automatic logic [7:0] f_pick(input logic [2:0] mode, input logic [7:0] other,
                                          input logic [7:0] sa, input logic [7:0] da);
        logic [7:0] f;
        unique case (mode)
            BF_ZERO:      f = 8'd0;
            BF_ONE:       f = 8'hff;
            BF_OTHER:     f = other;
            BF_INV_OTHER: f = 8'hff - other;
            BF_SRC_ALPHA: f = sa;
            BF_INV_SRC_A: f = 8'hff - sa;
            BF_DST_ALPHA: f = da;
            BF_INV_DST_A: f = 8'hff - da;
            default:      f = 8'd0;
        endcase
        return f;
    endfunction

    always_comb begin
        sf      = f_pick(i_src_factor, i_dst, i_src_alpha, i_dst_alpha);
        df      = f_pick(i_dst_factor, i_src, i_src_alpha, i_dst_alpha);
        sf_adj  = {1'b0, sf} + {8'd0, sf[7]};
        df_adj  = {1'b0, df} + {8'd0, df[7]};
        s_prod  = {9'd0, i_src} * {8'd0, sf_adj};
        d_prod  = {9'd0, i_dst} * {8'd0, df_adj};
        sum     = {1'b0, s_prod} + {1'b0, d_prod};
        shifted = sum[17:8];
        if (i_subtract) begin
            o_res = (i_dst > i_src) ? (i_dst - i_src) : 8'd0;
        end else begin
            o_res = (shifted > 10'd255) ? 8'hff : shifted[7:0];
        end
    end

endmodule

// File: hw/rtl/pbf_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_merge
// Picks blend, logic op or source, applies constant alpha and dither, and
// packs the masked store word.
// ----------------------------------------------------------------------------
module pbf_merge
    import pbf_pkg::*;
(
    input  t_cfg                  i_cfg,
    input  logic [1:0]            i_kind,
    input  t_rgba                 i_src,
    input  t_rgba                 i_dst,
    input  t_rgba                 i_lane_res,
    input  logic [PBF_WORD_W-1:0] i_old,
    input  logic                  i_x0,
    input  logic                  i_y0,
    output logic [PBF_WORD_W-1:0] o_wdata
);

    logic [31:0] s_word, d_word, l_word;
    t_rgba       r, c;
    logic [1:0]  bay;
    logic        cu, au;
    logic [23:0] rgb6;

    function automatic logic [7:0] f_dither(input logic [7:0] v, input logic [1:0] b);
        logic [8:0] t;
        t = {1'b0, v - {6'd0, v[7:6]}} + {7'd0, b};
        return {t[7:2], 2'b00};
    endfunction

    always_comb begin
        s_word = i_src;
        d_word = i_dst;
        unique case (i_cfg.logic_op)
            LOP_CLEAR:    l_word = 32'd0;
            LOP_AND:      l_word = s_word & d_word;
            LOP_AND_REV:  l_word = s_word & ~d_word;
            LOP_COPY:     l_word = s_word;
            LOP_AND_INV:  l_word = ~s_word & d_word;
            LOP_NOOP:     l_word = d_word;
            LOP_XOR:      l_word = s_word ^ d_word;
            LOP_OR:       l_word = s_word | d_word;
            LOP_NOR:      l_word = ~(s_word | d_word);
            LOP_EQUIV:    l_word = ~(s_word ^ d_word);
            LOP_INVERT:   l_word = ~d_word;
            LOP_OR_REV:   l_word = s_word | ~d_word;
            LOP_COPY_INV: l_word = ~s_word;
            LOP_OR_INV:   l_word = ~s_word | d_word;
            LOP_NAND:     l_word = ~(s_word & d_word);
            LOP_SET:      l_word = 32'hffff_ffff;
            default:      l_word = 32'd0;
        endcase

        priority if (i_cfg.mode_flags[MODE_BLEND]) r = i_lane_res;
        else if (i_cfg.mode_flags[MODE_LOGIC])     r = l_word;
        else                                       r = i_src;

        if (i_cfg.const_a_en) r.a = i_cfg.const_a_val;

        cu  = i_cfg.mode_flags[MODE_COLOR_UP];
        au  = i_cfg.mode_flags[MODE_ALPHA_UP];
        bay = BAYER[i_y0][i_x0];
        if (cu && i_cfg.mode_flags[MODE_DITHER] && i_cfg.pix_fmt == FMT_RGBA6) begin
            r.r = f_dither(r.r, bay);
            r.g = f_dither(r.g, bay);
            r.b = f_dither(r.b, bay);
        end

        // plain writes skip all of the above
        c = (i_kind == KIND_WRITE) ? i_src : r;

        rgb6 = {c.r[7:2], c.g[7:2], c.b[7:2], 6'd0};
        if (i_cfg.pix_fmt == FMT_RGBA6) begin
            priority if (cu && au) o_wdata = rgb6 | {18'd0, c.a[7:2]};
            else if (cu)           o_wdata = rgb6 | {18'd0, i_old[5:0]};
            else if (au)           o_wdata = {i_old[23:6], c.a[7:2]};
            else                   o_wdata = i_old;
        end else begin
            o_wdata = cu ? {c.r, c.g, c.b} : i_old;
        end
    end

endmodule

// File: hw/rtl/pixel_blend_framebuffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_blend_framebuffer
// Framebuffer pixel stage: blend, write or read one pixel of a colour store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | kind, pixel_x/y, in_rgba
//  out     | output    | o_out_valid / i_out_ready  | out_red/green/blue/alpha
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// Each transaction passes through accept, address multiply, store read,
// lane blend, merge and write-back, all through the single store port.
// After reset the store is cleared one word a cycle, all FB_WIDTH*FB_HEIGHT
// words (337920 by default), with o_in_ready low; config writes still land.
// A read result waits in the output register; a later read stalls in the
// merge step until that register is free.
// ----------------------------------------------------------------------------
module pixel_blend_framebuffer
    import pbf_pkg::*;
#(
    parameter int FB_WIDTH  = PBF_FB_WIDTH,
    parameter int FB_HEIGHT = PBF_FB_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [9:0] i_pixel_x,
    input  logic [9:0] i_pixel_y,
    input  logic [7:0] i_in_red,
    input  logic [7:0] i_in_green,
    input  logic [7:0] i_in_blue,
    input  logic [7:0] i_in_alpha,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha
);

    localparam int DEPTH  = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ADDR, S_READ, S_CALC, S_MERGE
    } t_state;

    t_state r_state;
    t_cfg   r_cfg;

    logic [PBF_WORD_W-1:0] r_mem [DEPTH];
    logic [ADDR_W-1:0]     r_clr;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_inside;
    logic [1:0]            r_kind;
    logic [9:0]            r_x, r_y;
    t_rgba                 r_src;
    logic [PBF_WORD_W-1:0] r_rdata;
    t_rgba                 r_lane_res;
    logic                  r_out_valid;
    t_rgba                 r_out;

    logic [20:0]           addr_full;
    logic                  in_frame;
    logic [PBF_WORD_W-1:0] old;
    t_rgba                 dst, lane_res;
    logic [PBF_WORD_W-1:0] wdata;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [PBF_WORD_W-1:0] mem_wdata;
    logic                  out_free;

    always_comb begin
        addr_full = {11'd0, r_x} + 21'(r_y) * 21'(FB_WIDTH);
        in_frame  = ({1'b0, r_x} < 11'(FB_WIDTH)) && ({1'b0, r_y} < 11'(FB_HEIGHT));
        old       = r_inside ? r_rdata : '0;
        dst       = f_decode(old, r_cfg.pix_fmt);
        out_free  = !r_out_valid || i_out_ready;
    end

    // four channel lanes
    pbf_lane u_lane_r (
        .i_src(r_src.r), .i_dst(dst.r), .i_src_alpha(r_src.a), .i_dst_alpha(dst.a),
        .i_src_factor(r_cfg.src_factor), .i_dst_factor(r_cfg.dst_factor),
        .i_subtract(r_cfg.mode_flags[MODE_SUBTRACT]), .o_res(lane_res.r)
    );
    pbf_lane u_lane_g (
        .i_src(r_src.g), .i_dst(dst.g), .i_src_alpha(r_src.a), .i_dst_alpha(dst.a),
        .i_src_factor(r_cfg.src_factor), .i_dst_factor(r_cfg.dst_factor),
        .i_subtract(r_cfg.mode_flags[MODE_SUBTRACT]), .o_res(lane_res.g)
    );
    pbf_lane u_lane_b (
        .i_src(r_src.b), .i_dst(dst.b), .i_src_alpha(r_src.a), .i_dst_alpha(dst.a),
        .i_src_factor(r_cfg.src_factor), .i_dst_factor(r_cfg.dst_factor),
        .i_subtract(r_cfg.mode_flags[MODE_SUBTRACT]), .o_res(lane_res.b)
    );
    pbf_lane u_lane_a (
        .i_src(r_src.a), .i_dst(dst.a), .i_src_alpha(r_src.a), .i_dst_alpha(dst.a),
        .i_src_factor(r_cfg.src_factor), .i_dst_factor(r_cfg.dst_factor),
        .i_subtract(r_cfg.mode_flags[MODE_SUBTRACT]), .o_res(lane_res.a)
    );

    pbf_merge u_merge (
        .i_cfg      (r_cfg),
        .i_kind     (r_kind),
        .i_src      (r_src),
        .i_dst      (dst),
        .i_lane_res (r_lane_res),
        .i_old      (old),
        .i_x0       (r_x[0]),
        .i_y0       (r_y[0]),
        .o_wdata    (wdata)
    );

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_we    = (r_state == S_MERGE) && r_inside &&
                        (r_kind == KIND_BLEND || r_kind == KIND_WRITE);
            mem_waddr = r_addr;
            mem_wdata = wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (r_state == S_READ) r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PIX_FMT:      r_cfg.pix_fmt      <= i_cfg_data[1:0];
                CFG_MODE_FLAGS:   r_cfg.mode_flags   <= i_cfg_data[5:0];
                CFG_SRC_FACTOR:   r_cfg.src_factor   <= i_cfg_data[2:0];
                CFG_DST_FACTOR:   r_cfg.dst_factor   <= i_cfg_data[2:0];
                CFG_LOGIC_OP:     r_cfg.logic_op     <= i_cfg_data[3:0];
                CFG_CONST_A_EN:   r_cfg.const_a_en   <= i_cfg_data[0];
                CFG_CONST_A_VAL:  r_cfg.const_a_val  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_MERGE && r_kind == KIND_READ && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready)                                      r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind  <= i_kind;
                        r_x     <= i_pixel_x;
                        r_y     <= i_pixel_y;
                        r_src   <= '{r: i_in_red, g: i_in_green, b: i_in_blue, a: i_in_alpha};
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_addr   <= in_frame ? addr_full[ADDR_W-1:0] : '0;
                    r_inside <= in_frame;
                    r_state  <= S_READ;
                end
                S_READ: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_lane_res <= lane_res;
                    r_state    <= S_MERGE;
                end
                S_MERGE: begin
                    if (r_kind == KIND_READ) begin
                        if (out_free) begin
                            r_out   <= dst;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out.r;
    assign o_out_green = r_out.g;
    assign o_out_blue  = r_out.b;
    assign o_out_alpha = r_out.a;

endmodule

// File: sim/tb_pixel_blend_framebuffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_blend_framebuffer
// Self-checking bench for the framebuffer pixel stage. Writes, blends and
// reads pixels under many register settings and idle/stall patterns. Every
// read is checked against a pixel-store predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_pixel_blend_framebuffer;
    import pbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 1500000;  // covers the store clearing pass
    localparam int DRAIN_CYCLES   = 12;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_kind;
    logic [9:0] i_pixel_x;
    logic [9:0] i_pixel_y;
    logic [7:0] i_in_red;
    logic [7:0] i_in_green;
    logic [7:0] i_in_blue;
    logic [7:0] i_in_alpha;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_red;
    logic [7:0] o_out_green;
    logic [7:0] o_out_blue;
    logic [7:0] o_out_alpha;

    pixel_blend_framebuffer u_top (.*);

    t_cfg        cfg_shadow;
    logic [23:0] pixel_mem [int];
    t_rgba       read_expect_q [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          idle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------ predictor
    function automatic t_rgba unpack_pixel(input logic [23:0] w);
        t_rgba c;
        if (cfg_shadow.pix_fmt == FMT_RGBA6) begin
            c.r = {w[23:18], w[23:22]};
            c.g = {w[17:12], w[17:16]};
            c.b = {w[11:6], w[11:10]};
            c.a = {w[5:0], w[5:4]};
        end else begin
            c = {w, 8'hff};
        end
        return c;
    endfunction

    function automatic logic [23:0] masked_pixel(input logic [23:0] old, input t_rgba c);
        logic        cu;
        logic        au;
        logic [23:0] rgb;
        cu = cfg_shadow.mode_flags[MODE_COLOR_UP];
        au = cfg_shadow.mode_flags[MODE_ALPHA_UP];
        if (cfg_shadow.pix_fmt == FMT_RGBA6) begin
            rgb = {c.r[7:2], c.g[7:2], c.b[7:2], 6'd0};
            if (cu && au) return rgb | c.a[7:2];
            if (cu) return rgb | old[5:0];
            if (au) return {old[23:6], c.a[7:2]};
            return old;
        end
        return cu ? c[31:8] : old;
    endfunction

    function automatic int blend_factor(input logic [2:0] sel, input int other,
                                        input int src_a, input int dst_a);
        case (sel)
            BF_ZERO:      return 0;
            BF_ONE:       return 255;
            BF_OTHER:     return other;
            BF_INV_OTHER: return 255 - other;
            BF_SRC_ALPHA: return src_a;
            BF_INV_SRC_A: return 255 - src_a;
            BF_DST_ALPHA: return dst_a;
            default:      return 255 - dst_a;
        endcase
    endfunction

    // applies one accepted transaction to the pixel store model;
    // returns 1 with the read data when the transaction yields a result
    function automatic bit pixel_update(input logic [1:0] kind, input logic [9:0] x,
                                        input logic [9:0] y, input t_rgba src,
                                        output t_rgba rd);
        bit          in_frame;
        int          addr;
        logic [23:0] old;
        t_rgba       dst;
        t_rgba       res;
        logic [31:0] word;
        int          s [4];
        int          d [4];
        int          r [4];
        int          sf;
        int          df;
        int          sum;
        in_frame = (x < PBF_FB_WIDTH) && (y < PBF_FB_HEIGHT);
        addr = int'(x) + int'(y) * PBF_FB_WIDTH;
        old = (in_frame && pixel_mem.exists(addr)) ? pixel_mem[addr] : 24'd0;
        dst = unpack_pixel(old);
        rd = dst;
        if (kind == KIND_READ) return 1'b1;
        if (kind == KIND_NONE || !in_frame) return 1'b0;
        if (kind == KIND_WRITE) begin
            pixel_mem[addr] = masked_pixel(old, src);
            return 1'b0;
        end
        for (int i = 0; i < 4; i++) begin
            s[i] = src[31-8*i -: 8];
            d[i] = dst[31-8*i -: 8];
            r[i] = s[i];
        end
        if (cfg_shadow.mode_flags[MODE_BLEND]) begin
            for (int i = 0; i < 4; i++) begin
                if (cfg_shadow.mode_flags[MODE_SUBTRACT]) begin
                    r[i] = d[i] > s[i] ? d[i] - s[i] : 0;
                end else begin
                    sf = blend_factor(cfg_shadow.src_factor, d[i], s[3], d[3]);
                    df = blend_factor(cfg_shadow.dst_factor, s[i], s[3], d[3]);
                    sf += sf >> 7;
                    df += df >> 7;
                    sum = (s[i] * sf + d[i] * df) >> 8;
                    r[i] = sum > 255 ? 255 : sum;
                end
            end
        end else if (cfg_shadow.mode_flags[MODE_LOGIC]) begin
            case (cfg_shadow.logic_op)
                LOP_CLEAR:    word = '0;
                LOP_AND:      word = src & dst;
                LOP_AND_REV:  word = src & ~dst;
                LOP_COPY:     word = src;
                LOP_AND_INV:  word = ~src & dst;
                LOP_NOOP:     word = dst;
                LOP_XOR:      word = src ^ dst;
                LOP_OR:       word = src | dst;
                LOP_NOR:      word = ~(src | dst);
                LOP_EQUIV:    word = ~(src ^ dst);
                LOP_INVERT:   word = ~dst;
                LOP_OR_REV:   word = src | ~dst;
                LOP_COPY_INV: word = ~src;
                LOP_OR_INV:   word = ~src | dst;
                LOP_NAND:     word = ~(src & dst);
                default:      word = '1;
            endcase
            for (int i = 0; i < 4; i++) r[i] = word[31-8*i -: 8];
        end
        if (cfg_shadow.const_a_en) r[3] = cfg_shadow.const_a_val;
        // 2x2 ordered dither on color lanes only, RGBA6 target
        if (cfg_shadow.mode_flags[MODE_COLOR_UP] && cfg_shadow.mode_flags[MODE_DITHER]
            && cfg_shadow.pix_fmt == FMT_RGBA6) begin
            for (int i = 0; i < 3; i++)
                r[i] = ((r[i] - (r[i] >> 6)) + BAYER[y[0]][x[0]]) & 8'hfc;
        end
        for (int i = 0; i < 4; i++) res[31-8*i -: 8] = r[i][7:0];
        pixel_mem[addr] = masked_pixel(old, res);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------ drivers
    task automatic send_pixel(input logic [1:0] kind, input logic [9:0] x,
                              input logic [9:0] y, input t_rgba c);
        t_rgba rd;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        {i_in_red, i_in_green, i_in_blue, i_in_alpha} <= c;
        do @(posedge i_clk); while (!o_in_ready);
        if (pixel_update(kind, x, y, c, rd)) read_expect_q.push_back(rd);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (read_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_PIX_FMT:      cfg_shadow.pix_fmt      = val[1:0];
            CFG_MODE_FLAGS:   cfg_shadow.mode_flags   = val[5:0];
            CFG_SRC_FACTOR:   cfg_shadow.src_factor   = val[2:0];
            CFG_DST_FACTOR:   cfg_shadow.dst_factor   = val[2:0];
            CFG_LOGIC_OP:     cfg_shadow.logic_op     = val[3:0];
            CFG_CONST_A_EN:   cfg_shadow.const_a_en   = val[0];
            default:          cfg_shadow.const_a_val  = val;
        endcase
    endtask

    task automatic load_config(input t_cfg c);
        drain();
        write_reg(CFG_PIX_FMT, 8'(c.pix_fmt));
        write_reg(CFG_MODE_FLAGS, 8'(c.mode_flags));
        write_reg(CFG_SRC_FACTOR, 8'(c.src_factor));
        write_reg(CFG_DST_FACTOR, 8'(c.dst_factor));
        write_reg(CFG_LOGIC_OP, 8'(c.logic_op));
        write_reg(CFG_CONST_A_EN, 8'(c.const_a_en));
        write_reg(CFG_CONST_A_VAL, c.const_a_val);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_rgba rand_color();
        return {rand_channel(), rand_channel(), rand_channel(), rand_channel()};
    endfunction

    // ------------------------------------------------------------ tests
    task automatic test_plain_write_read;
        t_cfg c;
        c = '0;
        c.mode_flags = 6'b110000;
        load_config(c);
        send_pixel(KIND_READ, 10'd5, 10'd5, '0);             // untouched pixel
        send_pixel(KIND_WRITE, 10'd0, 10'd0, 32'hffffffff);
        send_pixel(KIND_WRITE, 10'd639, 10'd527, 32'h12345678);
        send_pixel(KIND_READ, 10'd0, 10'd0, '0);
        send_pixel(KIND_READ, 10'd639, 10'd527, '0);
        send_pixel(KIND_WRITE, 10'd640, 10'd0, 32'haaaaaaaa); // off frame
        send_pixel(KIND_WRITE, 10'd1023, 10'd1023, 32'h55555555);
        send_pixel(KIND_READ, 10'd0, 10'd528, '0);
        send_pixel(KIND_NONE, 10'd0, 10'd0, 32'h00000000);    // unused kind
        send_pixel(KIND_READ, 10'd0, 10'd0, '0);
    endtask

    task automatic test_rgba6_masks;
        t_cfg c;
        c = '0;
        c.pix_fmt = FMT_RGBA6;
        for (int m = 0; m < 4; m++) begin
            c.mode_flags = 6'(m << MODE_COLOR_UP);
            load_config(c);
            send_pixel(KIND_WRITE, 10'd1, 10'd1, rand_color());
            send_pixel(KIND_READ, 10'd1, 10'd1, '0);
        end
        c.pix_fmt    = FMT_RGB8;
        c.mode_flags = 6'b100000;                            // alpha-only, RGB8
        load_config(c);
        send_pixel(KIND_WRITE, 10'd1, 10'd1, 32'h01020304);
        send_pixel(KIND_READ, 10'd1, 10'd1, '0);
    endtask

    task automatic test_blend_logic_dither;
        t_cfg c;
        c = '0;
        c.pix_fmt      = FMT_RGB8;
        c.mode_flags   = 6'b010001;
        c.src_factor   = BF_ONE;
        c.dst_factor   = BF_ONE;                             // saturating add
        load_config(c);
        send_pixel(KIND_BLEND, 10'd2, 10'd2, 32'hc0c0c0c0);
        send_pixel(KIND_BLEND, 10'd2, 10'd2, 32'hc0c0c0c0);
        send_pixel(KIND_READ, 10'd2, 10'd2, '0);
        c.mode_flags = 6'b010011;                            // subtract to floor
        load_config(c);
        send_pixel(KIND_BLEND, 10'd2, 10'd2, 32'h10ff2040);
        send_pixel(KIND_READ, 10'd2, 10'd2, '0);
        c.mode_flags = 6'b010101;                            // blend wins over logic op
        c.logic_op   = LOP_SET;
        load_config(c);
        send_pixel(KIND_BLEND, 10'd3, 10'd2, 32'h80808080);
        send_pixel(KIND_READ, 10'd3, 10'd2, '0);
        c.pix_fmt      = FMT_RGBA6;
        c.mode_flags   = 6'b111000;                          // dither, passthrough
        c.const_a_en   = 1'b1;
        c.const_a_val  = 8'hff;
        load_config(c);
        for (int i = 0; i < 4; i++) begin
            send_pixel(KIND_BLEND, 10'(i & 1), 10'(i >> 1), 32'hfd7f4100);
            send_pixel(KIND_READ, 10'(i & 1), 10'(i >> 1), '0);
        end
    endtask

    task automatic random_phase(input int n_items);
        t_cfg        c;
        logic [9:0]  bx;
        logic [9:0]  by;
        logic [9:0]  x;
        logic [9:0]  y;
        c = t_cfg'($bits(t_cfg)'($urandom));
        if ($urandom_range(3) == 0) c.mode_flags[MODE_COLOR_UP] = 1'b1;
        load_config(c);
        // a small window keeps read-modify-write hits on the same pixels
        bx = 10'($urandom_range(PBF_FB_WIDTH - 4));
        by = 10'($urandom_range(PBF_FB_HEIGHT - 4));
        if ($urandom_range(3) == 0) begin
            bx = 10'($urandom_range(1) ? PBF_FB_WIDTH - 4 : 0);
            by = 10'($urandom_range(1) ? PBF_FB_HEIGHT - 4 : 0);
        end
        for (int i = 0; i < n_items; i++) begin
            x = bx + 10'($urandom_range(3));
            y = by + 10'($urandom_range(3));
            if ($urandom_range(19) == 0) begin
                x = 10'($urandom);
                y = 10'($urandom);
            end
            case ($urandom_range(9))
                0, 1, 2, 3: send_pixel(KIND_BLEND, x, y, rand_color());
                4, 5:       send_pixel(KIND_WRITE, x, y, rand_color());
                6, 7, 8:    send_pixel(KIND_READ, x, y, rand_color());
                default:    send_pixel(2'($urandom_range(3)), x, y, rand_color());
            endcase
        end
    endtask

    task automatic test_random_traffic;
        t_cfg c;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int k = 0; k < 5; k++) random_phase(30);
        end
        // all-ones register extremes, then back to all zero
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        c = '1;
        c.pix_fmt = FMT_Z24;
        load_config(c);
        send_pixel(KIND_BLEND, 10'd7, 10'd7, 32'h89abcdef);
        send_pixel(KIND_READ, 10'd7, 10'd7, '0);
        load_config('0);
        send_pixel(KIND_BLEND, 10'd7, 10'd7, 32'h89abcdef);
        send_pixel(KIND_READ, 10'd7, 10'd7, '0);
    endtask

    // ------------------------------------------------------------ checker
    always @(posedge i_clk) begin
        t_rgba got;
        t_rgba want;
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_out_red, o_out_green, o_out_blue, o_out_alpha};
            if (read_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected read data %h", got);
            end else begin
                want = read_expect_q.pop_front();
                if (got.r !== want.r || got.g !== want.g || got.b !== want.b
                    || got.a !== want.a) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("read mismatch: expected %h, got %h", want, got);
                end
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        mismatches     = 0;
        idle_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_shadow     = '0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_PIX_FMT;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_kind         = KIND_READ;
        i_pixel_x      = '0;
        i_pixel_y      = '0;
        {i_in_red, i_in_green, i_in_blue, i_in_alpha} = '0;
        i_out_ready    = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_write_read();
        test_rgba6_masks();
        test_blend_logic_dither();
        test_random_traffic();
        drain();
        if (mismatches == 0 && read_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
